// ===== design/pwmpc_pkg.sv =====
// pwmpc_pkg: types, codes and constants of the pwm prescaler/period calculator
// used by every module of the block and by the channel interface
package pwmpc_pkg;

	localparam int COUNTER_BITS_DEF = 16;
	localparam int FREQ_W           = 22;
	localparam int DUTY_W           = 14;
	localparam int PULSE_W          = 17;
	localparam int OUT_W            = 16;

	localparam logic [FREQ_W-1:0] FREQ_MAX        = 22'd1000000;
	localparam int                PERIOD_MIN      = 100;
	localparam int                PERIOD_FALLBACK = 99;
	localparam int                FALLBACK_SCALE  = 100;
	localparam logic [DUTY_W-1:0] DUTY_FULL       = 14'd10000;

	// configuration port
	localparam int          ADDR_W          = 3;
	localparam int          DATA_W          = 32;
	localparam logic [31:0] CLK_HZ_RESET    = 32'd168000000;
	localparam logic [0:0]  REG_TIMER_CLOCK = 1'b0;

	localparam logic [1:0] TIMER_INVALID = 2'd3;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_TIMER = 2'd1,
		ST_BAD_FREQ  = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]        timer_index;
		logic [1:0]        channel;
		logic [FREQ_W-1:0] frequency_hz;
		logic [DUTY_W-1:0] duty_hundredths;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [1:0]         timer_out;
		logic [1:0]         channel_out;
		logic [OUT_W-1:0]   prescaler;
		logic [OUT_W-1:0]   period;
		logic [PULSE_W-1:0] pulse;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_P_GO,
		S_P_WAIT,
		S_MUL_Q,
		S_Q_GO,
		S_Q_WAIT,
		S_F_GO,
		S_F_WAIT,
		S_MUL_PL,
		S_PULSE,
		S_DONE
	} ctrl_state_t;

endpackage

// ===== design/pwmpc_if.sv =====
// pwmpc_if: valid/ready channel carrying one payload struct
// payload type comes from pwmpc_pkg at instantiation
interface pwmpc_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/pwmpc_cfg.sv =====
// pwmpc_cfg: apb-style register holding the timer input clock frequency
// depends on pwmpc_pkg
module pwmpc_cfg import pwmpc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output logic [31:0]       clk_hz
);
	logic [31:0] clk_hz_q;
	logic        reg_hit;

	assign reg_hit = (paddr[ADDR_W-1:2] == REG_TIMER_CLOCK);
	assign pready  = 1'b1;
	assign prdata  = reg_hit ? clk_hz_q : '0;
	assign clk_hz  = clk_hz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_hz_q <= CLK_HZ_RESET;
		end else if (psel && penable && pwrite && reg_hit) begin
			clk_hz_q <= pwdata;
		end
	end
endmodule

// ===== design/pwmpc_div.sv =====
// pwmpc_div: shared restoring divider, one quotient bit per cycle
// depends on pwmpc_pkg only through the importing convention
module pwmpc_div import pwmpc_pkg::*; #(
	parameter int NW = 32,
	parameter int DW = 39
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [NW-1:0] quotient
);
	localparam int CW  = (NW + 1 > DW) ? NW + 1 : DW;
	localparam int CNT = $clog2(NW + 1);

	logic [CNT-1:0] cnt_q;
	logic           done_q;
	logic [NW-1:0]  rem_q;
	logic [NW-1:0]  quo_q;
	logic [DW-1:0]  dvs_q;
	logic [CW-1:0]  trial;
	logic [CW-1:0]  diff;
	logic           fits;

	// shift in the next dividend bit and try the subtract
	assign trial = CW'({rem_q, quo_q[NW-1]});
	assign fits  = trial >= CW'(dvs_q);
	assign diff  = trial - CW'(dvs_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT'(1));
			if (start) begin
				cnt_q <= CNT'(NW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[NW-2:0], fits};
			rem_q <= fits ? diff[NW-1:0] : trial[NW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

// ===== design/pwmpc_ctrl.sv =====
// pwmpc_ctrl: sequencer, operand selection, shared multiplier and result register
// depends on pwmpc_pkg and pwmpc_if; drives the divider through its ports
module pwmpc_ctrl import pwmpc_pkg::*; #(
	parameter int COUNTER_BITS = COUNTER_BITS_DEF,
	parameter int NW           = 32,
	parameter int DW           = 39
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [31:0]   clk_hz,
	pwmpc_if.sink         req,
	pwmpc_if.source       rsp,
	output logic          div_start,
	output logic [NW-1:0] div_dividend,
	output logic [DW-1:0] div_divisor,
	input  logic          div_done,
	input  logic [NW-1:0] div_quo
);
	localparam int              CB     = COUNTER_BITS;
	localparam logic [NW-1:0]   MAXC_N = NW'((64'(1) << CB) - 64'(1));
	localparam logic [NW-1:0]   MIN_Q  = NW'(PERIOD_MIN + 1);
	localparam logic [CB-1:0]   PER_FB = CB'(PERIOD_FALLBACK);
	// divide by 10000 as a shift by 4, then a reciprocal multiply for 625;
	// (period+1)*duty/16 stays under 2^(CB+10)
	localparam int              XW     = CB + 10;
	localparam int              RS     = XW + 10;
	localparam logic [63:0]     RM64   = ((64'd1 << RS) + 64'd624) / 64'd625;
	localparam logic [XW:0]     RM     = (XW+1)'(RM64);

	ctrl_state_t state_q, state_d;

	logic [1:0]        tmr_q, chn_q;
	logic [FREQ_W-1:0] freq_q;
	logic [DUTY_W-1:0] duty_q;
	status_t           status_q;
	logic [CB-1:0]     p_q, psc_q, per_q;
	logic [PULSE_W-1:0] pulse_q;
	logic [DW-1:0]     prod_q;
	logic              rsp_valid_q;
	rsp_t              rsp_data_q;

	logic [CB:0]       mul_a;
	logic [FREQ_W-1:0] mul_b;
	logic [DW-1:0]     mul_p;
	logic [XW-1:0]     pl_x;
	logic [2*XW:0]     pl_prod;
	logic              req_acc, out_free;
	logic [DUTY_W-1:0] duty_clamp;

	assign req_acc    = req.valid && req.ready;
	assign out_free   = !rsp_valid_q || rsp.ready;
	assign duty_clamp = (req.data.duty_hundredths > DUTY_FULL) ? DUTY_FULL
	                                                           : req.data.duty_hundredths;

	// one multiplier, shared by the period divisor and the pulse dividend
	always_comb begin
		if (state_q == S_MUL_PL) begin
			mul_a = {1'b0, per_q} + (CB+1)'(1);
			mul_b = FREQ_W'(duty_q);
		end else begin
			mul_a = {1'b0, p_q} + (CB+1)'(1);
			mul_b = freq_q;
		end
		mul_p = DW'(mul_a) * DW'(mul_b);
	end

	// compare value: floor(prod/16) times the rounded-up reciprocal of 625
	assign pl_x    = prod_q[XW+3:4];
	assign pl_prod = (2*XW+1)'(pl_x) * (2*XW+1)'(RM);

	// divider operands
	always_comb begin
		div_dividend = NW'(clk_hz);
		div_divisor  = (DW'(freq_q) << CB) + DW'(freq_q);
		case (state_q)
			S_Q_GO:  div_divisor = prod_q;
			S_F_GO:  div_divisor = DW'(freq_q) * DW'(FALLBACK_SCALE);
			default: ;
		endcase
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		req.ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					if (req.data.timer_index == TIMER_INVALID ||
					    req.data.frequency_hz == '0 ||
					    req.data.frequency_hz > FREQ_MAX) begin
						state_d = S_DONE;
					end else begin
						state_d = S_P_GO;
					end
				end
			end
			S_P_GO: begin
				div_start = 1'b1;
				state_d   = S_P_WAIT;
			end
			S_P_WAIT: begin
				if (div_done) begin
					state_d = (div_quo <= MAXC_N) ? S_MUL_Q : S_F_GO;
				end
			end
			S_MUL_Q: state_d = S_Q_GO;
			S_Q_GO: begin
				div_start = 1'b1;
				state_d   = S_Q_WAIT;
			end
			S_Q_WAIT: begin
				if (div_done) begin
					if (div_quo >= MIN_Q && div_quo <= MAXC_N + NW'(1)) begin
						state_d = S_MUL_PL;
					end else begin
						state_d = S_F_GO;
					end
				end
			end
			S_F_GO: begin
				div_start = 1'b1;
				state_d   = S_F_WAIT;
			end
			S_F_WAIT: begin
				if (div_done) begin
					state_d = S_MUL_PL;
				end
			end
			S_MUL_PL: state_d = S_PULSE;
			S_PULSE:  state_d = S_DONE;
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		if (req_acc) begin
			tmr_q   <= req.data.timer_index;
			chn_q   <= req.data.channel;
			freq_q  <= req.data.frequency_hz;
			duty_q  <= duty_clamp;
			psc_q   <= '0;
			per_q   <= '0;
			pulse_q <= '0;
			if (req.data.timer_index == TIMER_INVALID) begin
				status_q <= ST_BAD_TIMER;
			end else if (req.data.frequency_hz == '0 ||
			             req.data.frequency_hz > FREQ_MAX) begin
				status_q <= ST_BAD_FREQ;
			end else begin
				status_q <= ST_OK;
			end
		end
		if (state_q == S_P_WAIT && div_done) begin
			p_q <= div_quo[CB-1:0];
		end
		if (state_q == S_MUL_Q || state_q == S_MUL_PL) begin
			prod_q <= mul_p;
		end
		if (state_q == S_Q_WAIT && div_done) begin
			psc_q <= p_q;
			per_q <= div_quo[CB-1:0] - CB'(1);
		end
		if (state_q == S_F_WAIT && div_done) begin
			per_q <= PER_FB;
			if (div_quo == '0) begin
				psc_q <= '0;
			end else if (div_quo - NW'(1) > MAXC_N) begin
				psc_q <= MAXC_N[CB-1:0];
			end else begin
				psc_q <= div_quo[CB-1:0] - CB'(1);
			end
		end
		if (state_q == S_PULSE) begin
			pulse_q <= PULSE_W'(pl_prod >> RS);
		end
		if (state_q == S_DONE && out_free) begin
			rsp_data_q.status      <= status_q;
			rsp_data_q.timer_out   <= tmr_q;
			rsp_data_q.channel_out <= chn_q;
			rsp_data_q.prescaler   <= OUT_W'(psc_q);
			rsp_data_q.period      <= OUT_W'(per_q);
			rsp_data_q.pulse       <= pulse_q;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;
endmodule

// ===== design/pwm_prescaler_period_calculator_unit.sv =====
// pwm_prescaler_period_calculator_unit: top level of the pwm setup calculator
// depends on pwmpc_pkg, pwmpc_if, pwmpc_cfg, pwmpc_div and pwmpc_ctrl
//
// usage
// - req channel: one transaction per pwm request (timer, channel, frequency,
//   duty); rsp channel: one transaction per request with status, echoes,
//   prescaler, auto-reload period and compare value
// - apb port: register 0 at byte address 0 is the timer input clock in hz; reads
//   return it; the user writes it only while no request is in flight (not enforced)
// - req.ready is high only while the sequencer is idle, so one request is
//   worked at a time; the result register lets the next request enter while
//   the previous result still waits on rsp
// - one shared restoring divider, one quotient bit per cycle, with
//   NW = max(32, COUNTER_BITS+1); a rejected request needs no division,
//   a found prescaler two, a fallback to period 99 up to three
// - a stalled receiver holds the finished result in the output register; the
//   sequencer waits in its final state until the register frees
// - reset clears the sequencer and the output valid and loads the clock
//   register with 168 mhz
module pwm_prescaler_period_calculator_unit import pwmpc_pkg::*; #(
	parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	pwmpc_if.sink             req,
	pwmpc_if.source           rsp
);
	// dividend holds the clock; quotients must reach 2^COUNTER_BITS for the range checks
	localparam int NW = (COUNTER_BITS + 1 > 32) ? COUNTER_BITS + 1 : 32;
	// divisor must hold (2^COUNTER_BITS+1)*frequency and (prescaler+1)*frequency
	localparam int DW = COUNTER_BITS + FREQ_W + 1;

	logic [31:0]   clk_hz;
	logic          div_start;
	logic [NW-1:0] div_dividend;
	logic [DW-1:0] div_divisor;
	logic          div_done;
	logic [NW-1:0] div_quo;

	pwmpc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.clk_hz  (clk_hz)
	);

	// sequencer: prescaler search, period check, fallback and compare value
	pwmpc_ctrl #(
		.COUNTER_BITS (COUNTER_BITS),
		.NW           (NW),
		.DW           (DW)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.clk_hz       (clk_hz),
		.req          (req),
		.rsp          (rsp),
		.div_start    (div_start),
		.div_dividend (div_dividend),
		.div_divisor  (div_divisor),
		.div_done     (div_done),
		.div_quo      (div_quo)
	);

	// the one divider every division by a variable goes through
	pwmpc_div #(
		.NW (NW),
		.DW (DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);
endmodule

// ===== design/pwmpc_chk.sv =====
// pwmpc_chk: port-level checks of the pwm setup calculator, bound to the top level
// depends on pwmpc_pkg
module pwmpc_chk import pwmpc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp_data
);
	// result held while the receiver stalls
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result changed while stalled");

	// one request at a time: no accept right after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while busy");

	// rejected requests carry zero settings
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status != ST_OK |->
		rsp_data.prescaler == '0 && rsp_data.period == '0 && rsp_data.pulse == '0)
		else $error("rejected request has nonzero settings");

	// an invalid timer always reports the timer error
	a_bad_timer: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.timer_out == TIMER_INVALID |->
		rsp_data.status == ST_BAD_TIMER)
		else $error("invalid timer not reported");
endmodule

bind pwm_prescaler_period_calculator_unit pwmpc_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

// ===== dv/tb_top.sv =====
// tb_top: self-checking bench for the pwm prescaler/period calculator
// depends on pwmpc_pkg, pwmpc_if and pwm_prescaler_period_calculator_unit
// drives requests and the apb clock register, predicts every result in a scoreboard
module tb_top;
	import pwmpc_pkg::*;

	// run limits, set loosely against the slowest request
	localparam int CYCLE_LIMIT   = 2000000;
	localparam int SETTLE_CYCLES = 150;
	localparam int PHASE_ITEMS   = 200;

	// corner requests at the reset clock of 168 mhz
	localparam int N_CORNERS = 20;
	localparam req_t CORNER_REQS [N_CORNERS] = '{
		'{TIMER_INVALID, 2'd0, 22'd0, 14'd0},         // bad timer wins over bad frequency
		'{TIMER_INVALID, 2'd3, 22'd1000, 14'd5000},   // bad timer, good frequency
		'{2'd0, 2'd1, 22'd0, 14'd100},                // zero frequency
		'{2'd1, 2'd2, 22'd1000001, 14'd100},          // just above the frequency limit
		'{2'd2, 2'd3, 22'h3FFFFF, 14'h3FFF},          // frequency and duty with every bit set
		'{2'd0, 2'd0, 22'd1, 14'd0},                  // slowest legal frequency, zero duty
		'{2'd1, 2'd1, 22'd1000000, 14'd10000},        // fastest legal frequency, full duty
		'{2'd2, 2'd2, 22'd1000, 14'd10001},           // duty just above full is clamped
		'{2'd0, 2'd3, 22'd50, 14'h3FFF},              // largest duty code
		'{2'd1, 2'd0, 22'd20000, 14'd2500},
		'{2'd2, 2'd1, 22'd16800, 14'd1},              // period 9999 with prescaler 0
		'{2'd0, 2'd2, 22'd2563, 14'd9999},            // first frequency that needs prescaler 1
		'{2'd1, 2'd3, 22'd2564, 14'd5000},
		'{2'd2, 2'd0, 22'd999999, 14'd3333},
		'{2'd0, 2'd1, 22'd2, 14'd7777},
		'{2'd1, 2'd2, 22'd7, 14'd8191},
		'{2'd2, 2'd3, 22'd1680000, 14'd50},           // above the limit with a valid timer
		'{2'd0, 2'd0, 22'h200000, 14'h2000},          // top frequency bit alone
		'{2'd1, 2'd1, 22'd65536, 14'd1234},
		'{2'd2, 2'd2, 22'd168, 14'd10000}
	};

	// fixed clock settings for the later phases; the last one runs with no idling
	localparam int N_CLOCKS = 7;
	localparam logic [31:0] CLOCK_SETTINGS [N_CLOCKS] = '{
		32'd1,           // slowest clock: everything falls back with prescaler 0
		32'hFFFF_FFFF,   // fastest clock the register holds
		32'd72000000,    // high frequencies fall back to period 99
		32'd1000000,
		32'd5000,
		32'd24000000,
		32'd168000000
	};

	// predicts the result of each accepted request and checks results in order
	class pwm_setup_board;
		logic [31:0] timer_clock;
		rsp_t        pending_setups [$];
		int          errors;

		function new();
			timer_clock = CLK_HZ_RESET;
			errors      = 0;
		endfunction

		// work out the timer setup a request should produce at the current clock
		function void note_request(req_t r);
			rsp_t            want;
			logic [63:0]     clk_hz;
			logic [63:0]     freq;
			logic [63:0]     duty;
			logic [63:0]     top;
			logic [63:0]     psc;
			logic [63:0]     quot;
			logic [63:0]     per;
			bit              found;
			clk_hz = 64'(timer_clock);
			freq   = 64'(r.frequency_hz);
			duty   = 64'(r.duty_hundredths);
			top    = (64'd1 << COUNTER_BITS_DEF) - 64'd1;
			want   = '0;
			want.status      = ST_OK;
			want.timer_out   = r.timer_index;
			want.channel_out = r.channel;
			if (r.timer_index == TIMER_INVALID) begin
				want.status = ST_BAD_TIMER;
			end else if (r.frequency_hz == '0 || r.frequency_hz > FREQ_MAX) begin
				want.status = ST_BAD_FREQ;
			end else begin
				// smallest prescaler that brings the count under the counter range
				found = 1'b0;
				psc   = clk_hz / ((top + 64'd2) * freq);
				per   = '0;
				if (psc <= top) begin
					quot = clk_hz / ((psc + 64'd1) * freq);
					if (quot >= 64'(PERIOD_MIN + 1) && quot <= top + 64'd1) begin
						found = 1'b1;
						per   = quot - 64'd1;
					end
				end
				if (!found) begin
					quot = clk_hz / (freq * 64'(FALLBACK_SCALE));
					psc  = (quot == 0) ? 64'd0 : quot - 64'd1;
					if (psc > top)
						psc = top;
					per = 64'(PERIOD_FALLBACK);
				end
				if (duty > 64'(DUTY_FULL))
					duty = 64'(DUTY_FULL);
				want.prescaler = psc[OUT_W-1:0];
				want.period    = per[OUT_W-1:0];
				want.pulse     = PULSE_W'(((per + 64'd1) * duty) / 64'(DUTY_FULL));
			end
			pending_setups.push_back(want);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(rsp_t got);
			rsp_t want;
			if (pending_setups.size() == 0) begin
				$display("%0t: result with nothing pending, expected none, actual %h",
					$time, got);
				errors++;
				return;
			end
			want = pending_setups.pop_front();
			compare_field("status", 32'(want.status), 32'(got.status));
			compare_field("timer_out", 32'(want.timer_out), 32'(got.timer_out));
			compare_field("channel_out", 32'(want.channel_out), 32'(got.channel_out));
			compare_field("prescaler", 32'(want.prescaler), 32'(got.prescaler));
			compare_field("period", 32'(want.period), 32'(got.period));
			compare_field("pulse", 32'(want.pulse), 32'(got.pulse));
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	pwmpc_if #(.payload_t(req_t)) req_if ();
	pwmpc_if #(.payload_t(rsp_t)) rsp_if ();

	pwm_setup_board board = new();

	// idling controls, switched off for the last phase
	bit req_gaps_on  = 1'b1;
	bit rsp_stall_on = 1'b1;
	int gap_pct      = 0;
	int cycles       = 0;

	pwm_prescaler_period_calculator_unit u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_if.sink),
		.rsp     (rsp_if.source)
	);

	// 4 unit clock period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// run guard: ends a hung run
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	// result side: accepted transactions are checked against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready)
			board.check_result(rsp_if.data);
	end

	// result side ready: random stall bursts between ready stretches
	initial begin
		rsp_if.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (rsp_stall_on && $urandom_range(0, 2) == 0) begin
				rsp_if.ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			rsp_if.ready <= 1'b1;
			// long ready stretches now and then so some spans see no stall at all
			if ($urandom_range(0, 7) == 0)
				repeat ($urandom_range(100, 400)) @(posedge clk);
			else
				repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	// one request transaction; valid stays high into the next call unless a gap follows
	task automatic send_request(input req_t r);
		req_if.valid <= 1'b1;
		req_if.data  <= r;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
		board.note_request(r);
		if (req_gaps_on && $urandom_range(0, 99) < gap_pct) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	// apb write of the timer clock: setup cycle, then access cycle
	task automatic write_timer_clock(input logic [31:0] hz);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(4 * int'(REG_TIMER_CLOCK));
		pwdata  <= hz;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		board.timer_clock = hz;
	endtask

	// let every predicted result come back, then a short settle
	task automatic drain_results();
		while (board.pending_setups.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// random requests: mostly legal with spread-out frequencies, some rejects
	task automatic run_random_requests(input int count);
		req_t r;
		int   bits;
		for (int n = 0; n < count; n++) begin
			// reroll the gap rate now and then, zero gives stretches with no idling
			if (n % 40 == 0)
				gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
			r.timer_index = ($urandom_range(0, 9) == 0) ? TIMER_INVALID
				: 2'($urandom_range(0, 2));
			r.channel = 2'($urandom_range(0, 3));
			case ($urandom_range(0, 9))
				0: r.frequency_hz = FREQ_W'($urandom_range(0, 22'h3FFFFF));
				1: begin
					case ($urandom_range(0, 3))
						0: r.frequency_hz = '0;
						1: r.frequency_hz = FREQ_W'(1);
						2: r.frequency_hz = FREQ_MAX;
						default: r.frequency_hz = FREQ_MAX + FREQ_W'(1);
					endcase
				end
				default: begin
					// log-spread so low and high frequencies both show up
					bits = $urandom_range(1, 20);
					r.frequency_hz = FREQ_W'($urandom_range(1, (1 << bits) - 1));
					if (r.frequency_hz > FREQ_MAX)
						r.frequency_hz = FREQ_W'($urandom_range(1, 1000000));
				end
			endcase
			r.duty_hundredths = ($urandom_range(0, 4) == 0)
				? DUTY_W'($urandom_range(0, 14'h3FFF))
				: DUTY_W'($urandom_range(0, 10000));
			send_request(r);
		end
	endtask

	initial begin
		// every input known from time zero, reset asserted before release
		arst_n       <= 1'b0;
		psel         <= 1'b0;
		penable      <= 1'b0;
		pwrite       <= 1'b0;
		paddr        <= '0;
		pwdata       <= '0;
		req_if.valid <= 1'b0;
		req_if.data  <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner requests at the reset clock
		gap_pct = 30;
		for (int i = 0; i < N_CORNERS; i++)
			send_request(CORNER_REQS[i]);
		req_if.valid <= 1'b0;
		drain_results();

		// one phase at a clock nobody picked
		write_timer_clock($urandom);
		run_random_requests(PHASE_ITEMS);
		req_if.valid <= 1'b0;
		drain_results();

		// fixed clocks including both extremes; the last phase runs at full rate
		for (int c = 0; c < N_CLOCKS; c++) begin
			if (c == N_CLOCKS - 1) begin
				req_gaps_on  = 1'b0;
				rsp_stall_on = 1'b0;
			end
			write_timer_clock(CLOCK_SETTINGS[c]);
			run_random_requests(PHASE_ITEMS);
			req_if.valid <= 1'b0;
			drain_results();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.pending_setups.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
